@@ sv/assert_macros.svh @@
// Assertion macros for the port checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/rmsd_pkg.sv @@
// Shared constants for the RGB matrix scan driver.
package rmsd_pkg;

    localparam int PANEL_COLUMNS_DEF = 32;
    localparam int PANEL_ROWS_DEF    = 16;

    localparam int ACTION_W   = 2;
    localparam int ROW_W      = 4;
    localparam int COLUMN_W   = 5;
    localparam int RGB_W      = 3;
    localparam int DWELL_W    = 16;
    localparam int ROW_ADDR_W = 3;

    localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd5;

    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FILL  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd3;

    localparam logic [1:0] PHASE_SETUP = 2'd0;
    localparam logic [1:0] PHASE_CLOCK = 2'd1;
    localparam logic [1:0] PHASE_LATCH = 2'd2;

endpackage

@@ sv/rmsd_frame_store.sv @@
// Frame store RAM: one write port and two registered read ports.
module rmsd_frame_store #(
    parameter int DEPTH = 512
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  logic [rmsd_pkg::RGB_W-1:0]    wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr_b,
    output logic [rmsd_pkg::RGB_W-1:0]    rd_data_a,
    output logic [rmsd_pkg::RGB_W-1:0]    rd_data_b
);
    import rmsd_pkg::*;

    logic [RGB_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

@@ sv/rgb_matrix_scan_driver.sv @@
// Top level of the RGB matrix scan driver: frame store control and scan sequencer.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    action row column red green blue
//   out      output     out_valid / out_stall  shift_clock latch row_address
//                                              upper_rgb lower_rgb output_enable
//   cfg      input      cfg_valid / cfg_ready  cfg_data (dwell ticks)
//
// A scan tick reads the frame store as it is taken and then loads the output
// register from the read data. A pixel write is done in the cycle it is taken.
// A fill or clear sweeps the frame store through its single write port.
// After reset the same clearing pass runs before any item is taken.
// A tick whose result finds the output register full waits until out_stall drops.
module rgb_matrix_scan_driver #(
    parameter int PANEL_COLUMNS = rmsd_pkg::PANEL_COLUMNS_DEF,
    parameter int PANEL_ROWS    = rmsd_pkg::PANEL_ROWS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [rmsd_pkg::ACTION_W-1:0]     action,
    input  logic [rmsd_pkg::ROW_W-1:0]        row,
    input  logic [rmsd_pkg::COLUMN_W-1:0]     column,
    input  logic                              red,
    input  logic                              green,
    input  logic                              blue,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              shift_clock,
    output logic                              latch,
    output logic [rmsd_pkg::ROW_ADDR_W-1:0]   row_address,
    output logic [rmsd_pkg::RGB_W-1:0]        upper_rgb,
    output logic [rmsd_pkg::RGB_W-1:0]        lower_rgb,
    output logic                              output_enable,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rmsd_pkg::DWELL_W-1:0]      cfg_data
);
    import rmsd_pkg::*;

    localparam int SCAN_ROWS = PANEL_ROWS / 2;
    localparam int DEPTH     = PANEL_ROWS * PANEL_COLUMNS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int SCOL_W    = $clog2(PANEL_COLUMNS);
    localparam int SROW_W    = $clog2(SCAN_ROWS);
    localparam int LOWER_OFS = SCAN_ROWS * PANEL_COLUMNS;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0]   wr_addr_reg, wr_addr_next;
    logic                sweep_clear_reg, sweep_clear_next;
    logic [RGB_W-1:0]    sweep_mask_reg, sweep_mask_next;

    logic [SROW_W-1:0]   scan_row_reg, scan_row_next;
    logic [SCOL_W-1:0]   scan_col_reg, scan_col_next;
    logic [1:0]          phase_reg, phase_next;
    logic [DWELL_W-1:0]  dwell_count_reg, dwell_count_next;
    logic [DWELL_W-1:0]  dwell_ticks_reg, dwell_ticks_next;

    logic                out_valid_reg, out_valid_next;
    logic                clk_out_reg, clk_out_next;
    logic                latch_reg, latch_next;
    logic [ROW_ADDR_W-1:0] row_addr_reg, row_addr_next;
    logic [RGB_W-1:0]    upper_reg, upper_next;
    logic [RGB_W-1:0]    lower_reg, lower_next;

    logic                in_take;
    logic                out_free;
    logic                sweep_live;
    logic                pix_in_range;
    logic [RGB_W-1:0]    color;
    logic [ADDR_W-1:0]   pix_addr;
    logic [ADDR_W-1:0]   upper_addr;
    logic [ADDR_W-1:0]   lower_addr;

    logic                mem_wr_en;
    logic [ADDR_W-1:0]   mem_wr_addr;
    logic [RGB_W-1:0]    mem_wr_data;
    logic                mem_rd_en;
    logic [ADDR_W-1:0]   mem_rd_addr_a;
    logic [RGB_W-1:0]    mem_rd_data_a;
    logic [RGB_W-1:0]    mem_rd_data_b;

    assign in_stall      = (state_reg != ST_IDLE);
    assign in_take       = in_valid && !in_stall;
    assign out_free      = !out_valid_reg || !out_stall;
    assign cfg_ready     = 1'b1;
    assign color         = {blue, green, red};
    assign sweep_live    = (cnt_reg < CNT_W'(DEPTH));

    assign pix_in_range  = (32'(row) < PANEL_ROWS) && (32'(column) < PANEL_COLUMNS);
    assign pix_addr      = ADDR_W'(32'(row) * PANEL_COLUMNS + 32'(column));
    assign upper_addr    = ADDR_W'(32'(scan_row_reg) * PANEL_COLUMNS + 32'(scan_col_reg));
    assign lower_addr    = ADDR_W'(32'(upper_addr) + LOWER_OFS);

    // During a sweep each entry is read and then rewritten in the cycle after the read.
    always_comb
    begin
        mem_wr_en     = 1'b0;
        mem_wr_addr   = pix_addr;
        mem_wr_data   = color;
        mem_rd_en     = 1'b0;
        mem_rd_addr_a = upper_addr;
        if (state_reg == ST_SWEEP)
        begin
            mem_wr_en     = wr_pend_reg;
            mem_wr_addr   = wr_addr_reg;
            mem_wr_data   = sweep_clear_reg ? '0 : (mem_rd_data_a | sweep_mask_reg);
            mem_rd_en     = sweep_live;
            mem_rd_addr_a = cnt_reg[ADDR_W-1:0];
        end
        else if (state_reg == ST_IDLE)
        begin
            mem_wr_en = in_take && (action == ACT_WRITE) && pix_in_range;
            mem_rd_en = 1'b1;
        end
    end

    rmsd_frame_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk       (clk),
        .wr_en     (mem_wr_en),
        .wr_addr   (mem_wr_addr),
        .wr_data   (mem_wr_data),
        .rd_en     (mem_rd_en),
        .rd_addr_a (mem_rd_addr_a),
        .rd_addr_b (lower_addr),
        .rd_data_a (mem_rd_data_a),
        .rd_data_b (mem_rd_data_b)
    );

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        wr_pend_next     = wr_pend_reg;
        wr_addr_next     = wr_addr_reg;
        sweep_clear_next = sweep_clear_reg;
        sweep_mask_next  = sweep_mask_reg;
        scan_row_next    = scan_row_reg;
        scan_col_next    = scan_col_reg;
        phase_next       = phase_reg;
        dwell_count_next = dwell_count_reg;
        dwell_ticks_next = dwell_ticks_reg;
        out_valid_next   = out_valid_reg && out_stall;
        clk_out_next     = clk_out_reg;
        latch_next       = latch_reg;
        row_addr_next    = row_addr_reg;
        upper_next       = upper_reg;
        lower_next       = lower_reg;

        if (cfg_valid && cfg_ready)
        begin
            dwell_ticks_next = cfg_data;
        end

        unique case (state_reg)
            ST_SWEEP:
            begin
                wr_pend_next = sweep_live;
                wr_addr_next = cnt_reg[ADDR_W-1:0];
                if (sweep_live)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_take)
                begin
                    case (action) inside
                        ACT_TICK:
                        begin
                            state_next = ST_EMIT;
                        end
                        ACT_FILL, ACT_CLEAR:
                        begin
                            state_next       = ST_SWEEP;
                            cnt_next         = '0;
                            wr_pend_next     = 1'b0;
                            sweep_clear_next = (action == ACT_CLEAR);
                            sweep_mask_next  = color;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    row_addr_next  = ROW_ADDR_W'(scan_row_reg);
                    unique case (phase_reg)
                        PHASE_LATCH:
                        begin
                            clk_out_next = 1'b1;
                            latch_next   = 1'b1;
                            upper_next   = '0;
                            lower_next   = '0;
                            if (dwell_count_reg >= dwell_ticks_reg)
                            begin
                                dwell_count_next = '0;
                                phase_next       = PHASE_SETUP;
                                scan_col_next    = '0;
                                scan_row_next    = (scan_row_reg == SROW_W'(SCAN_ROWS - 1))
                                                 ? '0 : scan_row_reg + SROW_W'(1);
                            end
                            else
                            begin
                                dwell_count_next = dwell_count_reg + DWELL_W'(1);
                            end
                        end
                        PHASE_CLOCK:
                        begin
                            clk_out_next = 1'b1;
                            latch_next   = 1'b0;
                            upper_next   = mem_rd_data_a;
                            lower_next   = mem_rd_data_b;
                            if (scan_col_reg == SCOL_W'(PANEL_COLUMNS - 1))
                            begin
                                scan_col_next    = '0;
                                phase_next       = PHASE_LATCH;
                                dwell_count_next = '0;
                            end
                            else
                            begin
                                scan_col_next = scan_col_reg + SCOL_W'(1);
                                phase_next    = PHASE_SETUP;
                            end
                        end
                        default:
                        begin
                            // Data setup; the unused phase code behaves the same way.
                            clk_out_next = 1'b0;
                            latch_next   = 1'b0;
                            upper_next   = mem_rd_data_a;
                            lower_next   = mem_rd_data_b;
                            phase_next   = PHASE_CLOCK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_SWEEP;
            cnt_reg         <= '0;
            wr_pend_reg     <= 1'b0;
            wr_addr_reg     <= '0;
            sweep_clear_reg <= 1'b1;
            sweep_mask_reg  <= '0;
            scan_row_reg    <= '0;
            scan_col_reg    <= '0;
            phase_reg       <= PHASE_SETUP;
            dwell_count_reg <= '0;
            dwell_ticks_reg <= DWELL_RESET;
            out_valid_reg   <= 1'b0;
            clk_out_reg     <= 1'b0;
            latch_reg       <= 1'b0;
            row_addr_reg    <= '0;
            upper_reg       <= '0;
            lower_reg       <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            wr_pend_reg     <= wr_pend_next;
            wr_addr_reg     <= wr_addr_next;
            sweep_clear_reg <= sweep_clear_next;
            sweep_mask_reg  <= sweep_mask_next;
            scan_row_reg    <= scan_row_next;
            scan_col_reg    <= scan_col_next;
            phase_reg       <= phase_next;
            dwell_count_reg <= dwell_count_next;
            dwell_ticks_reg <= dwell_ticks_next;
            out_valid_reg   <= out_valid_next;
            clk_out_reg     <= clk_out_next;
            latch_reg       <= latch_next;
            row_addr_reg    <= row_addr_next;
            upper_reg       <= upper_next;
            lower_reg       <= lower_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign shift_clock   = clk_out_reg;
    assign latch         = latch_reg;
    assign row_address   = row_addr_reg;
    assign upper_rgb     = upper_reg;
    assign lower_rgb     = lower_reg;
    assign output_enable = 1'b0;

endmodule

@@ sv/rmsd_port_checker.sv @@
// Port-level checker for the RGB matrix scan driver, with its bind.
`include "assert_macros.svh"

module rmsd_port_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       shift_clock,
    input logic       latch,
    input logic [2:0] row_address,
    input logic [2:0] upper_rgb,
    input logic [2:0] lower_rgb,
    input logic       output_enable
);

    // The panel is never blanked.
    `ASSERT_IMPL(a_oe_low, clk, rst_n, out_valid, !output_enable)

    // The latch is only raised after the last column clock, with clock held high.
    `ASSERT_IMPL(a_latch_clock, clk, rst_n, out_valid && latch, shift_clock)

    // No color data is driven while the latch is high.
    `ASSERT_IMPL(a_latch_blank, clk, rst_n, out_valid && latch, (upper_rgb == 3'd0) && (lower_rgb == 3'd0))

    // A stalled item stays on the port unchanged.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(latch) && $stable(shift_clock) && $stable(upper_rgb) && $stable(lower_rgb) && $stable(row_address))

endmodule

bind rgb_matrix_scan_driver rmsd_port_checker u_port_checker (.*);

@@ verif/tb.sv @@
// Testbench for the RGB matrix scan driver: directed and random items checked against a scan predictor.
module tb;
    import rmsd_pkg::*;

    localparam int COLS        = PANEL_COLUMNS_DEF;
    localparam int ROWS        = PANEL_ROWS_DEF;
    localparam int SCAN_ROWS   = ROWS / 2;
    localparam int PIXELS      = ROWS * COLS;
    localparam int PIX_AW      = $clog2(PIXELS);
    localparam int IDLE_PCT    = 23;
    localparam int HOLD_CYCLES = 300;
    localparam int SWEEP_WAIT  = 600;
    localparam int STALL_LIMIT = 5000;

    localparam logic [ROW_W-1:0]    ROW_MID      = ROW_W'(SCAN_ROWS);
    localparam logic [ROW_W-1:0]    ROW_MID_LAST = ROW_W'(SCAN_ROWS - 1);
    localparam logic [ROW_W-1:0]    ROW_LAST     = ROW_W'(ROWS - 1);
    localparam logic [COLUMN_W-1:0] COL_ONE      = COLUMN_W'(1);
    localparam logic [COLUMN_W-1:0] COL_LAST     = COLUMN_W'(COLS - 1);

    typedef struct packed {
        logic                  shift_clock;
        logic                  latch;
        logic [ROW_ADDR_W-1:0] row_address;
        logic [RGB_W-1:0]      upper_rgb;
        logic [RGB_W-1:0]      lower_rgb;
        logic                  output_enable;
    } panel_pins_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [ACTION_W-1:0]   action = ACT_TICK;
    logic [ROW_W-1:0]      row = '0;
    logic [COLUMN_W-1:0]   column = '0;
    logic                  red = 1'b0;
    logic                  green = 1'b0;
    logic                  blue = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  shift_clock;
    logic                  latch;
    logic [ROW_ADDR_W-1:0] row_address;
    logic [RGB_W-1:0]      upper_rgb;
    logic [RGB_W-1:0]      lower_rgb;
    logic                  output_enable;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [DWELL_W-1:0]    cfg_data = '0;

    // Predicted panel state and the pin levels still owed by the block.
    logic [RGB_W-1:0]   pixels [PIXELS];
    int                 scan_row_q;
    int                 scan_col_q;
    logic [1:0]         phase_q;
    logic [DWELL_W-1:0] dwell_cnt_q;
    logic [DWELL_W-1:0] dwell_q;
    panel_pins_t        pins_due [$];

    int          mismatches = 0;
    logic        tx_idle = 1'b0;
    logic        rx_idle = 1'b0;
    logic        hold_arm = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;

    rgb_matrix_scan_driver u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .row           (row),
        .column        (column),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .shift_clock   (shift_clock),
        .latch         (latch),
        .row_address   (row_address),
        .upper_rgb     (upper_rgb),
        .lower_rgb     (lower_rgb),
        .output_enable (output_enable),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic logic [PIX_AW-1:0] pix_idx(input int r, input int c);
        return PIX_AW'(r * COLS + c);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("tb: mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // Applies one accepted item to the predicted panel and queues the pins a tick produces.
    task automatic advance_panel(input logic [ACTION_W-1:0] act, input logic [ROW_W-1:0] r,
                                 input logic [COLUMN_W-1:0] c, input logic [RGB_W-1:0] rgb);
        panel_pins_t p;
        p = '0;
        if (act == ACT_WRITE) begin
            if (int'(r) < ROWS && int'(c) < COLS)
                pixels[pix_idx(int'(r), int'(c))] = rgb;
        end
        else if (act == ACT_FILL) begin
            for (int i = 0; i < PIXELS; i++)
                pixels[PIX_AW'(i)] = pixels[PIX_AW'(i)] | rgb;
        end
        else if (act == ACT_CLEAR) begin
            for (int i = 0; i < PIXELS; i++)
                pixels[PIX_AW'(i)] = '0;
        end
        else begin
            p.row_address = scan_row_q[ROW_ADDR_W-1:0];
            p.output_enable = 1'b0;
            if (phase_q == PHASE_LATCH) begin
                p.shift_clock = 1'b1;
                p.latch = 1'b1;
                if (dwell_cnt_q >= dwell_q) begin
                    dwell_cnt_q = '0;
                    phase_q = PHASE_SETUP;
                    scan_col_q = 0;
                    scan_row_q = (scan_row_q + 1 >= SCAN_ROWS) ? 0 : scan_row_q + 1;
                end
                else begin
                    dwell_cnt_q = dwell_cnt_q + 1'b1;
                end
            end
            else begin
                // The lower half shows the row half a panel further down.
                p.upper_rgb = pixels[pix_idx(scan_row_q, scan_col_q)];
                p.lower_rgb = pixels[pix_idx(scan_row_q + SCAN_ROWS, scan_col_q)];
                if (phase_q == PHASE_CLOCK) begin
                    p.shift_clock = 1'b1;
                    if (scan_col_q + 1 >= COLS) begin
                        scan_col_q = 0;
                        phase_q = PHASE_LATCH;
                        dwell_cnt_q = '0;
                    end
                    else begin
                        scan_col_q++;
                        phase_q = PHASE_SETUP;
                    end
                end
                else begin
                    phase_q = PHASE_CLOCK;
                end
            end
            pins_due.push_back(p);
        end
    endtask

    // Offers one item and returns at the edge where it is taken.
    task automatic drive_item(input logic [ACTION_W-1:0] act, input logic [ROW_W-1:0] r,
                              input logic [COLUMN_W-1:0] c, input logic [RGB_W-1:0] rgb);
        while (tx_idle && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        row <= r;
        column <= c;
        red <= rgb[0];
        green <= rgb[1];
        blue <= rgb[2];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_panel(act, r, c, rgb);
    endtask

    task automatic random_item();
        int pick;
        logic [ACTION_W-1:0] act;
        pick = $urandom_range(99);
        if (pick < 60)
            act = ACT_TICK;
        else if (pick < 94)
            act = ACT_WRITE;
        else if (pick < 97)
            act = ACT_FILL;
        else
            act = ACT_CLEAR;
        drive_item(act, ROW_W'($urandom), COLUMN_W'($urandom), RGB_W'($urandom));
    endtask

    // Fills and clears give no result, so a sweep may still run once the queue is empty.
    task automatic settle_block();
        in_valid <= 1'b0;
        while (pins_due.size() != 0)
            @(posedge clk);
        repeat (SWEEP_WAIT) @(posedge clk);
    endtask

    task automatic write_dwell(input logic [DWELL_W-1:0] v);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        dwell_q = v;
    endtask

    task automatic check_pins();
        panel_pins_t want;
        if (pins_due.size() == 0) begin
            report_mismatch("result with none expected",
                            int'({shift_clock, latch, row_address, upper_rgb, lower_rgb,
                                  output_enable}), 0);
        end
        else begin
            want = pins_due.pop_front();
            if (shift_clock !== want.shift_clock)
                report_mismatch("shift_clock", int'(shift_clock), int'(want.shift_clock));
            if (latch !== want.latch)
                report_mismatch("latch", int'(latch), int'(want.latch));
            if (row_address !== want.row_address)
                report_mismatch("row_address", int'(row_address), int'(want.row_address));
            if (upper_rgb !== want.upper_rgb)
                report_mismatch("upper_rgb", int'(upper_rgb), int'(want.upper_rgb));
            if (lower_rgb !== want.lower_rgb)
                report_mismatch("lower_rgb", int'(lower_rgb), int'(want.lower_rgb));
            if (output_enable !== want.output_enable)
                report_mismatch("output_enable", int'(output_enable),
                                int'(want.output_enable));
        end
    endtask

    // Result side: checks each taken result and drives the stall, including the long hold.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            check_pins();
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_arm != hold_seen) begin
            hold_seen <= hold_arm;
            hold_left <= HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= rx_idle && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Corner pixels, every color, every action, and ticks with junk in the unused fields.
    task automatic test_directed();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        drive_item(ACT_WRITE, '0, '0, 3'b001);
        drive_item(ACT_WRITE, ROW_MID, '0, 3'b100);
        drive_item(ACT_WRITE, ROW_LAST, COL_LAST, 3'b111);
        drive_item(ACT_WRITE, ROW_MID_LAST, COL_LAST, 3'b010);
        drive_item(ACT_WRITE, '0, COL_ONE, 3'b110);
        drive_item(ACT_WRITE, ROW_MID, COL_ONE, 3'b011);
        drive_item(ACT_TICK, '0, '0, 3'b000);
        drive_item(ACT_TICK, ROW_LAST, COL_LAST, 3'b111);
        drive_item(ACT_TICK, '0, '0, 3'b000);
        drive_item(ACT_TICK, '0, '0, 3'b000);
        // Bits already set must survive a fill.
        drive_item(ACT_FILL, '0, '0, 3'b010);
        drive_item(ACT_TICK, '0, '0, 3'b000);
        drive_item(ACT_TICK, '0, '0, 3'b000);
        drive_item(ACT_FILL, ROW_LAST, COL_LAST, 3'b000);
        drive_item(ACT_TICK, '0, '0, 3'b000);
        drive_item(ACT_CLEAR, ROW_LAST, COL_LAST, 3'b111);
        drive_item(ACT_TICK, '0, '0, 3'b000);
        drive_item(ACT_TICK, '0, '0, 3'b000);
        drive_item(ACT_FILL, '0, '0, 3'b101);
        drive_item(ACT_TICK, '0, '0, 3'b000);
    endtask

    // The result side holds off for a long stretch while ticks keep coming.
    task automatic test_backpressure();
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        hold_arm <= ~hold_arm;
        repeat (60) drive_item(ACT_TICK, ROW_W'($urandom), COLUMN_W'($urandom),
                               RGB_W'($urandom));
    endtask

    task automatic test_dwell_extremes();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        write_dwell('0);
        repeat (150) random_item();
        write_dwell('1);
        repeat (250) random_item();
        // The dwell count is far past the new setting, so the next latch tick ends the row.
        write_dwell(16'd3);
        repeat (100) random_item();
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 6; ph++) begin
            write_dwell(($urandom_range(3) == 0) ? DWELL_W'($urandom_range(1))
                                                 : DWELL_W'($urandom_range(2, 12)));
            tx_idle = (ph != 2);
            rx_idle = (ph != 2);
            repeat (200) random_item();
        end
    endtask

    initial begin
        for (int i = 0; i < PIXELS; i++)
            pixels[PIX_AW'(i)] = '0;
        scan_row_q = 0;
        scan_col_q = 0;
        phase_q = PHASE_SETUP;
        dwell_cnt_q = '0;
        dwell_q = DWELL_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_dwell_extremes();
        test_random();
        settle_block();
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
